/* hw/rtl/rtsf_pkg.sv */
// Shared types, constants and codes for the resistive touch sample filter.
package rtsf_pkg;

	// Default build-time sizes
	localparam int GROUP_SIZE_DEF    = 5;
	localparam int TRIM_EACH_END_DEF = 1;
	localparam int SAMPLE_BITS_DEF   = 12;
	localparam int QUEUE_DEPTH       = 4;

	// Field and port widths
	localparam int SAMPLE_IN_W  = 12;
	localparam int SAMPLE_W_MAX = 16;
	localparam int COORD_W      = 16;
	localparam int AGREE_W      = 12;
	localparam int S_TDATA_W    = 16;
	localparam int M_TDATA_W    = 64;
	localparam int M_TUSER_W    = 3;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int Q_FRAC       = 14;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RAW_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AGREE_RANGE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_GAIN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET    = 3'd5;

	// Register reset values
	localparam logic [AGREE_W-1:0]        AGREE_RST = 12'd50;
	localparam logic signed [COORD_W-1:0] GAIN_RST  = 16'sd16384;

	localparam logic [COORD_W-1:0] PEN_UP_COORD = 16'hFFFF;

	// Group position within a scan: X, Y, X, Y
	localparam logic [1:0] GRP_FIRST_X  = 2'd0;
	localparam logic [1:0] GRP_FIRST_Y  = 2'd1;
	localparam logic [1:0] GRP_SECOND_X = 2'd2;
	localparam logic [1:0] GRP_LAST     = 2'd3;

	// Job kinds handed from front to back
	localparam logic JOB_SCAN  = 1'b0;
	localparam logic JOB_PENUP = 1'b1;

	// One job: a finished scan or a pen-up event
	typedef struct packed {
		logic                    kind;
		logic                    clr;
		logic [SAMPLE_W_MAX-1:0] fx;
		logic [SAMPLE_W_MAX-1:0] fy;
		logic [SAMPLE_W_MAX-1:0] sx;
		logic [SAMPLE_W_MAX-1:0] sy;
	} rtsf_job_t;

endpackage

/* hw/rtl/rtsf_front.sv */
// Front end: slot tracking, trimmed-mean pipeline per group and job issue.
module rtsf_front #(
	parameter int GROUP_SIZE    = rtsf_pkg::GROUP_SIZE_DEF,
	parameter int TRIM_EACH_END = rtsf_pkg::TRIM_EACH_END_DEF,
	parameter int SAMPLE_BITS   = rtsf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               pen_down,
	input  logic [rtsf_pkg::SAMPLE_IN_W-1:0]   sample,
	input  logic                               clear_catch,
	output logic                               job_valid,
	input  logic                               job_ready,
	output rtsf_pkg::rtsf_job_t                job
);
	import rtsf_pkg::*;

	localparam int POS_W   = $clog2(GROUP_SIZE);
	localparam int BUF_N   = GROUP_SIZE - 1;
	localparam int BI_W    = (BUF_N > 1) ? $clog2(BUF_N) : 1;
	localparam int CNT_RAW = GROUP_SIZE - 2 * TRIM_EACH_END;
	localparam int LO      = (CNT_RAW < 1) ? GROUP_SIZE / 2 : TRIM_EACH_END;
	localparam int CNT     = (CNT_RAW < 1) ? 1 : CNT_RAW;
	localparam int RANK_W  = $clog2(GROUP_SIZE + 1);
	localparam int SUM_W   = SAMPLE_BITS + $clog2(GROUP_SIZE);
	localparam int DIV_L   = $clog2(CNT);
	localparam int SH      = SUM_W + DIV_L;
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam longint RECIP = ((64'd1 << SH) + CNT - 1) / CNT;
	localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

	localparam logic [1:0] TOK_NONE  = 2'd0;
	localparam logic [1:0] TOK_GROUP = 2'd1;
	localparam logic [1:0] TOK_PENUP = 2'd2;

	logic                   en, acc, last, clr_now;
	logic [POS_W-1:0]       pos_q, pos_nxt;
	logic [1:0]             grp_q, grp_nxt;
	logic                   clr_acc_q, clr_acc_nxt;
	logic [1:0]             tok_in;
	logic [SAMPLE_BITS-1:0] samp;
	logic [SAMPLE_BITS-1:0] buf_q [BUF_N];
	logic [SAMPLE_BITS-1:0] vec_in [GROUP_SIZE];

	logic [1:0]             tok_s1, tok_s2, tok_s3, tok_s4;
	logic [1:0]             grp_s1, grp_s2, grp_s3, grp_s4;
	logic                   clr_s1, clr_s2, clr_s3, clr_s4;
	logic [SAMPLE_BITS-1:0] vec_s1 [GROUP_SIZE];
	logic [SAMPLE_BITS-1:0] vec_s2 [GROUP_SIZE];
	logic [GROUP_SIZE-1:0]  keep_c, keep_s2;
	logic [RANK_W-1:0]      rank_c [GROUP_SIZE];
	logic [SUM_W-1:0]       sum_c, sum_s3;
	logic [PROD_W-1:0]      prod_c;
	logic [SAMPLE_BITS-1:0] mean_s4;
	logic [SAMPLE_BITS-1:0] fx_q, fy_q, sx_q;

	// Whole front stalls only when a job is waiting on a full queue
	assign job_valid = (tok_s4 == TOK_PENUP) || ((tok_s4 == TOK_GROUP) && (grp_s4 == GRP_LAST));
	assign en        = !job_valid || job_ready;
	assign in_ready  = en;
	assign acc       = in_valid && en;

	assign samp    = SAMPLE_BITS'(SAMPLE_W_MAX'(sample));
	assign last    = (pos_q == POS_W'(GROUP_SIZE - 1));
	assign clr_now = clr_acc_q | clear_catch;

	// Slot classification
	always_comb begin
		tok_in      = TOK_NONE;
		pos_nxt     = pos_q;
		grp_nxt     = grp_q;
		clr_acc_nxt = clr_now;
		if (!pen_down) begin
			tok_in      = TOK_PENUP;
			pos_nxt     = '0;
			grp_nxt     = '0;
			clr_acc_nxt = 1'b0;
		end else if (last) begin
			tok_in  = TOK_GROUP;
			pos_nxt = '0;
			grp_nxt = grp_q + 2'd1;
			if (grp_q == GRP_LAST) begin
				clr_acc_nxt = 1'b0;
			end
		end else begin
			pos_nxt = pos_q + POS_W'(1);
		end
	end

	// Group vector: stored samples plus the one arriving now
	always_comb begin
		for (int i = 0; i < BUF_N; i++) begin
			vec_in[i] = buf_q[i];
		end
		vec_in[GROUP_SIZE-1] = samp;
	end

	// Rank of each element, ties broken by slot order
	always_comb begin
		for (int i = 0; i < GROUP_SIZE; i++) begin
			rank_c[i] = '0;
			for (int j = 0; j < GROUP_SIZE; j++) begin
				if (j != i) begin
					if ((vec_s1[j] < vec_s1[i]) || ((vec_s1[j] == vec_s1[i]) && (j < i))) begin
						rank_c[i] = rank_c[i] + RANK_W'(1);
					end
				end
			end
			keep_c[i] = (rank_c[i] >= RANK_W'(LO)) && (rank_c[i] < RANK_W'(LO + CNT));
		end
	end

	// Sum of the kept middle elements
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < GROUP_SIZE; i++) begin
			if (keep_s2[i]) begin
				sum_c = sum_c + SUM_W'(vec_s2[i]);
			end
		end
	end

	// Floor divide by the kept count via reciprocal
	assign prod_c = PROD_W'(sum_s3) * PROD_W'(RECIP_V);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			grp_q     <= '0;
			clr_acc_q <= 1'b0;
			tok_s1    <= TOK_NONE;
			tok_s2    <= TOK_NONE;
			tok_s3    <= TOK_NONE;
			tok_s4    <= TOK_NONE;
		end else if (en) begin
			tok_s1 <= acc ? tok_in : TOK_NONE;
			tok_s2 <= tok_s1;
			tok_s3 <= tok_s2;
			tok_s4 <= tok_s3;
			if (acc) begin
				pos_q     <= pos_nxt;
				grp_q     <= grp_nxt;
				clr_acc_q <= clr_acc_nxt;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (en) begin
			if (acc && pen_down && !last) begin
				buf_q[pos_q[BI_W-1:0]] <= samp;
			end
			grp_s1  <= grp_q;
			clr_s1  <= clr_now;
			vec_s1  <= vec_in;
			grp_s2  <= grp_s1;
			clr_s2  <= clr_s1;
			vec_s2  <= vec_s1;
			keep_s2 <= keep_c;
			grp_s3  <= grp_s2;
			clr_s3  <= clr_s2;
			sum_s3  <= sum_c;
			grp_s4  <= grp_s3;
			clr_s4  <= clr_s3;
			mean_s4 <= prod_c[SH +: SAMPLE_BITS];
			if (tok_s4 == TOK_GROUP) begin
				case (grp_s4)
					GRP_FIRST_X:  fx_q <= mean_s4;
					GRP_FIRST_Y:  fy_q <= mean_s4;
					GRP_SECOND_X: sx_q <= mean_s4;
					default: ;
				endcase
			end
		end
	end

	// Job word
	always_comb begin
		job      = '0;
		job.kind = (tok_s4 == TOK_PENUP) ? JOB_PENUP : JOB_SCAN;
		job.clr  = clr_s4;
		job.fx   = SAMPLE_W_MAX'(fx_q);
		job.fy   = SAMPLE_W_MAX'(fy_q);
		job.sx   = SAMPLE_W_MAX'(sx_q);
		job.sy   = SAMPLE_W_MAX'(mean_s4);
	end

`ifndef SYNTH
	// slot position never passes the end of a group
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(GROUP_SIZE - 1))
		else $error("group slot position out of range");

	// a pen-up word leaves the group counters at the scan start
	a_penup_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !pen_down) |=> (pos_q == '0) && (grp_q == '0) && (tok_s1 == TOK_PENUP))
		else $error("pen-up did not restart the scan");
`endif

endmodule

/* hw/rtl/rtsf_queue.sv */
// Short job queue between front and back.
module rtsf_queue #(
	parameter int DEPTH = rtsf_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  rtsf_pkg::rtsf_job_t push_job,
	output logic                pop_valid,
	input  logic                pop_ready,
	output rtsf_pkg::rtsf_job_t pop_job
);
	import rtsf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rtsf_job_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push, pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_job    = mem_q[rd_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

`ifndef SYNTH
	// fill count stays within the depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue fill count overflow");

	// pointers meet whenever the queue is empty or full
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == CNT_W'(DEPTH)) |-> (wr_q == rd_q))
		else $error("queue pointers disagree with fill count");
`endif

endmodule

/* hw/rtl/rtsf_back.sv */
// Back end: agreement check, averaging, gain/offset scaling and touch state.
module rtsf_back #(
	parameter int SAMPLE_BITS = rtsf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [rtsf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rtsf_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              job_valid,
	output logic                              job_ready,
	input  rtsf_pkg::rtsf_job_t               job,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [rtsf_pkg::COORD_W-1:0]      pos_x,
	output logic [rtsf_pkg::COORD_W-1:0]      pos_y,
	output logic [rtsf_pkg::COORD_W-1:0]      start_x,
	output logic [rtsf_pkg::COORD_W-1:0]      start_y,
	output logic                              pressed,
	output logic                              caught,
	output logic                              reading_ok
);
	import rtsf_pkg::*;

	localparam int PW  = COORD_W + SAMPLE_BITS + 1;
	localparam int TW  = ((PW > COORD_W + Q_FRAC) ? PW : COORD_W + Q_FRAC) + 1;
	localparam int QW  = TW - Q_FRAC;

	logic                         raw_q;
	logic [AGREE_W-1:0]           agree_q;
	logic signed [COORD_W-1:0]    xg_q, xo_q, yg_q, yo_q;

	logic                         ben;
	logic [SAMPLE_BITS-1:0]       fx, fy, sx, sy, dx, dy;
	logic [SAMPLE_BITS:0]         sumx, sumy;
	logic                         ok_c;

	logic                         valid_s1, kind_s1, clr_s1, ok_s1;
	logic [SAMPLE_BITS-1:0]       ax_s1, ay_s1;
	logic                         valid_s2, kind_s2, clr_s2, ok_s2;
	logic [SAMPLE_BITS-1:0]       ax_s2, ay_s2;
	logic signed [PW-1:0]         px_s2, py_s2;

	logic                         pressed_q, catch_q, ok_q;
	logic [COORD_W-1:0]           cur_x_q, cur_y_q, first_x_q, first_y_q;
	logic                         pressed_n, catch_n, ok_n;
	logic [COORD_W-1:0]           cur_x_n, cur_y_n, first_x_n, first_y_n;
	logic [COORD_W-1:0]           cx, cy;
	logic                         out_valid_q;

	// floor((p + off * 2^14) / 2^14), clamped to the coordinate range
	function automatic logic [COORD_W-1:0] scale_fn(input logic signed [PW-1:0] p,
			input logic signed [COORD_W-1:0] off);
		logic signed [TW-1:0] t;
		logic [QW-1:0]        q;
		logic [COORD_W-1:0]   r;
		t = TW'(p) + (TW'(off) <<< Q_FRAC);
		q = t[TW-1:Q_FRAC];
		if (t[TW-1]) begin
			r = '0;
		end else if (|q[QW-1:COORD_W]) begin
			r = '1;
		end else begin
			r = q[COORD_W-1:0];
		end
		return r;
	endfunction

	// Result slot free or being emptied
	assign ben       = !out_valid_q || out_ready;
	assign job_ready = ben;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q   <= 1'b0;
			agree_q <= AGREE_RST;
			xg_q    <= GAIN_RST;
			xo_q    <= '0;
			yg_q    <= GAIN_RST;
			yo_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RAW_MODE:    raw_q   <= cfg_data[0];
				REG_AGREE_RANGE: agree_q <= cfg_data[AGREE_W-1:0];
				REG_X_GAIN:      xg_q    <= $signed(cfg_data);
				REG_X_OFFSET:    xo_q    <= $signed(cfg_data);
				REG_Y_GAIN:      yg_q    <= $signed(cfg_data);
				REG_Y_OFFSET:    yo_q    <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Stage 1: agreement and pair average
	assign fx   = job.fx[SAMPLE_BITS-1:0];
	assign fy   = job.fy[SAMPLE_BITS-1:0];
	assign sx   = job.sx[SAMPLE_BITS-1:0];
	assign sy   = job.sy[SAMPLE_BITS-1:0];
	assign dx   = (fx >= sx) ? fx - sx : sx - fx;
	assign dy   = (fy >= sy) ? fy - sy : sy - fy;
	assign sumx = {1'b0, fx} + {1'b0, sx};
	assign sumy = {1'b0, fy} + {1'b0, sy};
	assign ok_c = (SAMPLE_W_MAX'(dx) < SAMPLE_W_MAX'(agree_q))
		&& (SAMPLE_W_MAX'(dy) < SAMPLE_W_MAX'(agree_q));

	// Stage 3: new touch state, which is also the result word
	always_comb begin
		cx        = raw_q ? COORD_W'(ax_s2) : scale_fn(px_s2, xo_q);
		cy        = raw_q ? COORD_W'(ay_s2) : scale_fn(py_s2, yo_q);
		pressed_n = pressed_q;
		catch_n   = catch_q & ~clr_s2;
		cur_x_n   = cur_x_q;
		cur_y_n   = cur_y_q;
		first_x_n = first_x_q;
		first_y_n = first_y_q;
		ok_n      = 1'b0;
		if (kind_s2 == JOB_SCAN) begin
			if (ok_s2) begin
				cur_x_n = cx;
				cur_y_n = cy;
				ok_n    = 1'b1;
			end
			if (!pressed_q) begin
				pressed_n = 1'b1;
				catch_n   = 1'b1;
				first_x_n = cur_x_n;
				first_y_n = cur_y_n;
			end
		end else begin
			if (pressed_q) begin
				pressed_n = 1'b0;
			end else begin
				first_x_n = '0;
				first_y_n = '0;
				cur_x_n   = PEN_UP_COORD;
				cur_y_n   = PEN_UP_COORD;
			end
		end
	end

	// Control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			pressed_q   <= 1'b0;
			catch_q     <= 1'b0;
			ok_q        <= 1'b0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			first_x_q   <= '0;
			first_y_q   <= '0;
		end else if (ben) begin
			valid_s1    <= job_valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
			if (valid_s2) begin
				pressed_q <= pressed_n;
				catch_q   <= catch_n;
				ok_q      <= ok_n;
				cur_x_q   <= cur_x_n;
				cur_y_q   <= cur_y_n;
				first_x_q <= first_x_n;
				first_y_q <= first_y_n;
			end
		end
	end

	// Payload stages, multiply registered before the offset add
	always_ff @(posedge clk) begin
		if (ben) begin
			kind_s1 <= job.kind;
			clr_s1  <= job.clr;
			ok_s1   <= ok_c;
			ax_s1   <= sumx[SAMPLE_BITS:1];
			ay_s1   <= sumy[SAMPLE_BITS:1];
			kind_s2 <= kind_s1;
			clr_s2  <= clr_s1;
			ok_s2   <= ok_s1;
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			px_s2   <= PW'(xg_q) * PW'($signed({1'b0, ax_s1}));
			py_s2   <= PW'(yg_q) * PW'($signed({1'b0, ay_s1}));
		end
	end

	assign out_valid  = out_valid_q;
	assign pos_x      = cur_x_q;
	assign pos_y      = cur_y_q;
	assign start_x    = first_x_q;
	assign start_y    = first_y_q;
	assign pressed    = pressed_q;
	assign caught     = catch_q;
	assign reading_ok = ok_q;

`ifndef SYNTH
	// an agreed reading is only ever reported with the pen held
	a_ok_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ok_q) |-> pressed_q)
		else $error("reading_ok without pressed");

	// catch flag only sets together with a new press
	a_catch_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(catch_q) |-> $rose(pressed_q))
		else $error("catch set without a new press");

	// pen-up coordinates always come with a cleared start position
	a_penup_start: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pressed_q && (cur_x_q == PEN_UP_COORD) && !ok_q
			&& (cur_y_q == PEN_UP_COORD) && $changed(cur_x_q))
		|-> (first_x_q == '0) && (first_y_q == '0))
		else $error("pen-up position with stale start");
`endif

endmodule

/* hw/rtl/resistive_touch_sample_filter.sv */
// Top level of the resistive touch sample filter: front, job queue and back.
// Takes one sample word per cycle unless stalled; with the pen down the words run
// X x GROUP_SIZE, Y x GROUP_SIZE, X x GROUP_SIZE, Y x GROUP_SIZE, and each group gives a
// trimmed mean (rank compare, masked sum, reciprocal multiply over four front stages).
// A result word comes out for every pen-up word and for every completed scan; other
// words give none. The sustained rate is one input word per cycle, set by the front
// pipeline; a four-entry job queue and a three-stage back end (agreement check,
// one 16-bit gain multiply per axis, offset add with clamp) let the result side stall
// on its own, and the input stalls only once that queue is full. Configuration writes
// are always taken (cfg_ready is tied high) and must be made while the block is idle.
module resistive_touch_sample_filter #(
	parameter int GROUP_SIZE    = rtsf_pkg::GROUP_SIZE_DEF,
	parameter int TRIM_EACH_END = rtsf_pkg::TRIM_EACH_END_DEF,
	parameter int SAMPLE_BITS   = rtsf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [rtsf_pkg::S_TDATA_W-1:0]     s_tdata,   // sample[11:0], clear_catch[12], zero pad
	input  logic [0:0]                         s_tuser,   // pen_down[0]
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [rtsf_pkg::M_TDATA_W-1:0]     m_tdata,   // pos_x, pos_y, start_x, start_y
	output logic [rtsf_pkg::M_TUSER_W-1:0]     m_tuser,   // pressed[0], caught[1], reading_ok[2]
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rtsf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rtsf_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rtsf_pkg::*;

	rtsf_job_t          fr_job, q_job;
	logic               fr_valid, fr_ready, q_valid, q_ready;
	logic [COORD_W-1:0] pos_x, pos_y, start_x, start_y;
	logic               pressed, caught, reading_ok;

	assign cfg_ready = 1'b1;

	rtsf_front #(
		.GROUP_SIZE    (GROUP_SIZE),
		.TRIM_EACH_END (TRIM_EACH_END),
		.SAMPLE_BITS   (SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.pen_down    (s_tuser[0]),
		.sample      (s_tdata[SAMPLE_IN_W-1:0]),
		.clear_catch (s_tdata[SAMPLE_IN_W]),
		.job_valid   (fr_valid),
		.job_ready   (fr_ready),
		.job         (fr_job)
	);

	rtsf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_job   (fr_job),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_job    (q_job)
	);

	rtsf_back #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.job_valid  (q_valid),
		.job_ready  (q_ready),
		.job        (q_job),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.start_x    (start_x),
		.start_y    (start_y),
		.pressed    (pressed),
		.caught     (caught),
		.reading_ok (reading_ok)
	);

	assign m_tdata = {start_y, start_x, pos_y, pos_x};
	assign m_tuser = {reading_ok, caught, pressed};

endmodule
